// ----- sv/asfd_pkg.sv -----
// asfd_pkg: encodings, register indexes, reset values and sample expansion
// functions of the audio sample format decoder.
// No dependencies; used by the interfaces, the top level and its checker.
package asfd_pkg;

	localparam int DataByteW    = 8;
	localparam int SampleW      = 32;
	localparam int ChanIndexW   = 3;
	localparam int EncW         = 3;
	localparam int ChanCountW   = 4;
	localparam int FramesW      = 32;
	localparam int PendingW     = 24;
	localparam int CfgDataW     = 32;
	localparam int CfgIndexW    = 2;
	localparam int MaxChannels  = 8;

	typedef enum logic [EncW-1:0] {
		ENC_U8      = 3'd0,
		ENC_S16     = 3'd1,
		ENC_S24     = 3'd2,
		ENC_S32     = 3'd3,
		ENC_MULAW   = 3'd4,
		ENC_ALAW    = 3'd5,
		ENC_FLOAT32 = 3'd6
	} enc_t;

	// encoding code left unused by enc_t: bytes under it are dropped
	localparam logic [EncW-1:0] EncReserved = 3'd7;

	typedef enum logic [CfgIndexW-1:0] {
		REG_SAMPLE_ENCODING  = 2'd0,
		REG_CHANNEL_COUNT    = 2'd1,
		REG_FRAMES_PER_BLOCK = 2'd2
	} reg_index_t;

	localparam logic [EncW-1:0]       EncReset    = ENC_S16;
	localparam logic [ChanCountW-1:0] ChanReset   = 4'd1;
	localparam logic [FramesW-1:0]    FramesReset = 32'd1;

	typedef struct packed {
		logic [SampleW-1:0] value;
		logic               clip;
	} float_res_t;

	// bytes making up one sample; the reserved code counts as one
	function automatic logic [2:0] bytes_for(input logic [EncW-1:0] enc);
		case (enc)
			ENC_S16:     bytes_for = 3'd2;
			ENC_S24:     bytes_for = 3'd3;
			ENC_S32:     bytes_for = 3'd4;
			ENC_FLOAT32: bytes_for = 3'd4;
			default:     bytes_for = 3'd1;
		endcase
	endfunction

	// G.711 mu-law to 16-bit linear, placed in the top half of Q1.31
	function automatic logic [SampleW-1:0] mulaw_q31(input logic [7:0] b);
		logic [7:0]         u;
		logic [15:0]        mag;
		logic [SampleW-1:0] q;
		u   = ~b;
		mag = (({9'd0, u[3:0], 3'b000} + 16'h0084) << u[6:4]) - 16'h0084;
		q   = {mag, 16'h0000};
		mulaw_q31 = u[7] ? (32'd0 - q) : q;
	endfunction

	// G.711 A-law to 16-bit linear, placed in the top half of Q1.31
	function automatic logic [SampleW-1:0] alaw_q31(input logic [7:0] b);
		logic [7:0]         a;
		logic [15:0]        mag;
		logic [SampleW-1:0] q;
		a = b ^ 8'h55;
		if (a[6:4] == 3'd0)
			mag = {8'd0, a[3:0], 4'h0} + 16'd8;
		else
			mag = ({8'd0, a[3:0], 4'h0} + 16'h0108) << (a[6:4] - 3'd1);
		q = {mag, 16'h0000};
		alaw_q31 = a[7] ? q : (32'd0 - q);
	endfunction

	// IEEE single to Q1.31: truncate toward zero, saturate, NaN gives zero
	function automatic float_res_t float_q31(input logic [31:0] w);
		logic               neg;
		logic [7:0]         ex;
		logic [22:0]        mant;
		logic [7:0]         rsh;
		logic [SampleW-1:0] mag;
		float_res_t         r;
		neg  = w[31];
		ex   = w[30:23];
		mant = w[22:0];
		rsh  = 8'd119 - ex;
		mag  = '0;
		r.clip  = 1'b0;
		r.value = '0;
		if (ex == 8'hFF && mant != 23'd0) begin
			r.clip = 1'b1;
		end else if (ex >= 8'd127) begin
			if (neg && ex == 8'd127 && mant == 23'd0) begin
				r.value = 32'h8000_0000;
			end else begin
				r.clip  = 1'b1;
				r.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
		end else begin
			if (ex == 8'd0)
				mag = '0;
			else if (ex >= 8'd119)
				mag = {8'd0, 1'b1, mant} << ex[2:0] - 3'd7;
			else if (rsh >= 8'd32)
				mag = '0;
			else
				mag = {8'd0, 1'b1, mant} >> rsh[4:0];
			r.value = neg ? (32'd0 - mag) : mag;
		end
		float_q31 = r;
	endfunction

endpackage

// ----- sv/asfd_if.sv -----
// asfd_if: byte and sample channel interfaces (valid/ready handshake).
// Depends on asfd_pkg for field widths.
interface asfd_byte_if;
	logic                            valid;
	logic                            ready;
	logic [asfd_pkg::DataByteW-1:0]  data_byte;
	logic                            restart_frame;

	modport source (output valid, output data_byte, output restart_frame, input ready);
	modport sink   (input valid, input data_byte, input restart_frame, output ready);
endinterface

interface asfd_sample_if;
	logic                             valid;
	logic                             ready;
	logic [asfd_pkg::SampleW-1:0]     sample_value;
	logic [asfd_pkg::ChanIndexW-1:0]  channel_index;
	logic                             frame_end;
	logic                             block_end;
	logic                             clipped;

	modport source (output valid, output sample_value, output channel_index,
		output frame_end, output block_end, output clipped, input ready);
	modport sink   (input valid, input sample_value, input channel_index,
		input frame_end, input block_end, input clipped, output ready);
endinterface

// ----- sv/audio_sample_format_decoder.sv -----
// audio_sample_format_decoder: WAV payload byte stream to Q1.31 samples.
// Depends on asfd_pkg and the channel interfaces in asfd_if.sv.
//
// Usage
//  - bytes (sink): one little-endian payload byte per transfer. restart_frame
//    set on a transfer drops any part-assembled sample and zeroes the channel
//    and frame counters before that byte is used.
//  - samples (source): one transfer per completed sample, Q1.31 value with
//    its channel, end-of-frame, end-of-block and float clip marks.
//  - cfg_write_en/cfg_index/cfg_data: register writes (encoding, channel
//    count, frames per block), only while the block is idle.
// Latency: the sample appears on samples the cycle after the byte that
// completes it. Throughput: one byte per cycle while the output is not stalled,
// set by the single output register; assembly, table expansion and normalisation
// sit between the byte input and that register.
// Stalls: bytes.ready stays high while the output register is empty or its
// contents are being taken this cycle; otherwise the upstream is held.
// Bytes that only add to a sample are accepted under the same rule.
// Reset: encoding s16, one channel, one frame per block, counters cleared,
// output register empty.
module audio_sample_format_decoder #(
	parameter int MAX_CHANNELS = asfd_pkg::MaxChannels
) (
	input  logic                              clk,
	input  logic                              arst_n,
	asfd_byte_if.sink                         bytes,
	asfd_sample_if.source                     samples,
	input  logic                              cfg_write_en,
	input  logic [asfd_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [asfd_pkg::CfgDataW-1:0]     cfg_data
);

	// counter width covers both the 4-bit count register and MAX_CHANNELS
	localparam int NCW = ($clog2(MAX_CHANNELS + 1) > asfd_pkg::ChanCountW) ?
		$clog2(MAX_CHANNELS + 1) : asfd_pkg::ChanCountW;

	// configuration
	logic [asfd_pkg::EncW-1:0]       enc_q;
	logic [asfd_pkg::ChanCountW-1:0] chan_count_q;
	logic [asfd_pkg::FramesW-1:0]    fpb_q;

	// assembly and position state
	logic [asfd_pkg::PendingW-1:0]   pending_q;
	logic [1:0]                      pos_q;
	logic [NCW-1:0]                  chan_q;
	logic [asfd_pkg::FramesW-1:0]    frames_q;

	// output register
	logic                            out_valid_q;
	logic [asfd_pkg::SampleW-1:0]    value_q;
	logic [asfd_pkg::ChanIndexW-1:0] chan_idx_q;
	logic                            fend_q;
	logic                            bend_q;
	logic                            clip_q;

	logic                            in_xfer;
	logic                            restart;
	logic [asfd_pkg::PendingW-1:0]   pend;
	logic [1:0]                      pos;
	logic [NCW-1:0]                  chan;
	logic [asfd_pkg::FramesW-1:0]    frames;
	logic [2:0]                      size;
	logic                            rsvd;
	logic                            partial;
	logic [asfd_pkg::PendingW-1:0]   pend_next;
	logic [31:0]                     word;
	logic [asfd_pkg::SampleW-1:0]    q;
	logic                            clip;
	asfd_pkg::float_res_t            fres;
	logic [NCW-1:0]                  nch;
	logic [asfd_pkg::FramesW-1:0]    fpb;
	logic                            fend;
	logic                            bend;

	assign bytes.ready = !out_valid_q || samples.ready;
	assign in_xfer     = bytes.valid && bytes.ready;

	// restart acts before the byte
	assign restart = bytes.restart_frame;
	assign pend    = restart ? '0 : pending_q;
	assign pos     = restart ? '0 : pos_q;
	assign chan    = restart ? '0 : chan_q;
	assign frames  = restart ? '0 : frames_q;

	assign size    = asfd_pkg::bytes_for(enc_q);
	assign rsvd    = (enc_q == asfd_pkg::EncReserved);
	assign partial = ({1'b0, pos} + 3'd1) < size;

	assign pend_next = pend | ({16'd0, bytes.data_byte} << {pos, 3'b000});

	// held low bytes (as many as the sample needs) plus this byte on top;
	// also covers an encoding change with bytes already held
	always_comb begin
		case (size)
			3'd2:    word = {16'd0, bytes.data_byte, pend[7:0]};
			3'd3:    word = {8'd0, bytes.data_byte, pend[15:0]};
			3'd4:    word = {bytes.data_byte, pend[23:0]};
			default: word = {24'd0, bytes.data_byte};
		endcase
	end

	assign fres = asfd_pkg::float_q31(word);

	always_comb begin
		clip = 1'b0;
		case (enc_q)
			asfd_pkg::ENC_U8:      q = {word[7:0] - 8'd128, 24'd0};
			asfd_pkg::ENC_S16:     q = {word[15:0], 16'd0};
			asfd_pkg::ENC_S24:     q = {word[23:0], 8'd0};
			asfd_pkg::ENC_S32:     q = word;
			asfd_pkg::ENC_MULAW:   q = asfd_pkg::mulaw_q31(word[7:0]);
			asfd_pkg::ENC_ALAW:    q = asfd_pkg::alaw_q31(word[7:0]);
			default: begin
				q    = fres.value;
				clip = fres.clip;
			end
		endcase
	end

	// out-of-range counts: zero acts as one, above MAX_CHANNELS clamps
	always_comb begin
		if (chan_count_q == '0)
			nch = NCW'(1);
		else if (NCW'(chan_count_q) > NCW'(MAX_CHANNELS))
			nch = NCW'(MAX_CHANNELS);
		else
			nch = NCW'(chan_count_q);
	end

	assign fpb  = (fpb_q == '0) ? 32'd1 : fpb_q;
	assign fend = ({1'b0, chan} + 1'b1) >= {1'b0, nch};
	assign bend = fend && (({1'b0, frames} + 33'd1) >= {1'b0, fpb});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q        <= asfd_pkg::EncReset;
			chan_count_q <= asfd_pkg::ChanReset;
			fpb_q        <= asfd_pkg::FramesReset;
		end else if (cfg_write_en) begin
			case (cfg_index)
				asfd_pkg::REG_SAMPLE_ENCODING:  enc_q <= cfg_data[asfd_pkg::EncW-1:0];
				asfd_pkg::REG_CHANNEL_COUNT:
					chan_count_q <= cfg_data[asfd_pkg::ChanCountW-1:0];
				asfd_pkg::REG_FRAMES_PER_BLOCK: fpb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// assembly, channel and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			pos_q     <= '0;
			chan_q    <= '0;
			frames_q  <= '0;
		end else if (in_xfer) begin
			if (rsvd) begin
				// reserved encoding: byte dropped, only a restart has effect
				pending_q <= pend;
				pos_q     <= pos;
				chan_q    <= chan;
				frames_q  <= frames;
			end else if (partial) begin
				pending_q <= pend_next;
				pos_q     <= pos + 2'd1;
				chan_q    <= chan;
				frames_q  <= frames;
			end else begin
				pending_q <= '0;
				pos_q     <= '0;
				if (fend) begin
					chan_q   <= '0;
					frames_q <= bend ? '0 : frames + 32'd1;
				end else begin
					chan_q   <= chan + 1'b1;
					frames_q <= frames;
				end
			end
		end
	end

	// output register: loaded by a completing byte, emptied by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (bytes.ready) begin
			out_valid_q <= in_xfer && !rsvd && !partial;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !rsvd && !partial) begin
			value_q    <= q;
			chan_idx_q <= chan[asfd_pkg::ChanIndexW-1:0];
			fend_q     <= fend;
			bend_q     <= bend;
			clip_q     <= clip;
		end
	end

	assign samples.valid         = out_valid_q;
	assign samples.sample_value  = value_q;
	assign samples.channel_index = chan_idx_q;
	assign samples.frame_end     = fend_q;
	assign samples.block_end     = bend_q;
	assign samples.clipped       = clip_q;

endmodule

// ----- sv/asfd_checker.sv -----
// asfd_checker: port-level assertions for audio_sample_format_decoder,
// attached by the bind below. Depends on asfd_pkg for widths.
module asfd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [asfd_pkg::SampleW-1:0]      out_value,
	input logic                              out_fend,
	input logic                              out_bend
);

	// a stalled sample keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("sample changed while stalled");

	// block end only ever closes a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_bend || out_fend)
		else $error("block end without frame end");

	// an empty output register never holds up the byte side
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a new sample follows a byte transfer in the previous cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("sample appeared without a byte transfer");

endmodule

bind audio_sample_format_decoder asfd_checker u_asfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bytes.valid),
	.in_ready  (bytes.ready),
	.out_valid (samples.valid),
	.out_ready (samples.ready),
	.out_value (samples.sample_value),
	.out_fend  (samples.frame_end),
	.out_bend  (samples.block_end)
);

// ----- dv/audio_sample_format_decoder_test.sv -----
// audio_sample_format_decoder_test: checks the WAV payload decoder end to end. A directed
// script comes first, then random phases, scored against typed rows or a local decoder model.
// Depends on asfd_pkg, the channel interfaces in asfd_if.sv and the decoder RTL.
`timescale 1ns / 1ps

module audio_sample_format_decoder_test;
	import asfd_pkg::*;

	localparam int ClkPeriod    = 10;
	localparam int DrainCycles  = 4;     // margin after the output register has drained
	localparam int RandomBytes  = 1500;
	localparam int ScriptLen    = 37;
	// float exponent at which the 24-bit significand already sits at Q1.31 scale:
	// shift = (ex - 127) + 31 - 23
	localparam int Q31Exp = 119;

	typedef struct packed {
		logic [SampleW-1:0]    value;
		logic [ChanIndexW-1:0] chan;
		logic                  fend;
		logic                  bend;
		logic                  clip;
	} pcm_sample_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_BYTE,
		ROW_BYTE_CHECKED
	} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		reg_index_t          idx;
		logic [CfgDataW-1:0] wdata;
		logic [7:0]          b;
		logic                rs;
		pcm_sample_t         want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_write_en;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	asfd_byte_if   byte_link ();
	asfd_sample_if sample_link ();

	audio_sample_format_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.bytes        (byte_link),
		.samples      (sample_link),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// ---------------------------------------------------------------------------
	// Decoder model: register copies and assembly state
	// ---------------------------------------------------------------------------
	logic [EncW-1:0]       enc_reg;
	logic [ChanCountW-1:0] chans_reg;
	logic [FramesW-1:0]    frames_reg;
	logic [PendingW-1:0]   held_bytes;    // earlier bytes of the sample, LSB first
	logic [1:0]            held_count;
	logic [ChanIndexW-1:0] chan_now;
	logic [FramesW-1:0]    frames_seen;   // frames completed in the current block

	pcm_sample_t due_samples [$];         // samples still to arrive, oldest first

	int errors;
	int bytes_moved;
	int samples_seen;
	int clips_seen;
	int block_ends_seen;
	int phases_run;
	bit src_steady;
	bit sink_steady;

	dir_row_t    script [ScriptLen];
	pcm_sample_t got_sample;
	pcm_sample_t want_sample;

	function automatic int unsigned sample_bytes(input logic [EncW-1:0] e);
		case (e)
			ENC_S16:              return 2;
			ENC_S24:              return 3;
			ENC_S32, ENC_FLOAT32: return 4;
			default:              return 1;
		endcase
	endfunction

	// G.711 expansions: (2m+33) scaled by segment, 2m+1 in A-law segment 0; mu-law bias 132
	function automatic logic [SampleW-1:0] mu_expand(input logic [7:0] code);
		logic [7:0]         inv;
		int                 mag;
		logic [SampleW-1:0] q;
		inv = ~code;
		mag = ((2 * int'(inv[3:0]) + 33) << (int'(inv[6:4]) + 2)) - 132;
		q   = 32'(mag) << 16;
		return inv[7] ? 32'd0 - q : q;
	endfunction

	function automatic logic [SampleW-1:0] a_expand(input logic [7:0] code);
		logic [7:0]         flip;
		int                 mag;
		logic [SampleW-1:0] q;
		flip = code ^ 8'h55;
		if (flip[6:4] == 3'd0)
			mag = (2 * int'(flip[3:0]) + 1) << 3;
		else
			mag = (2 * int'(flip[3:0]) + 33) << (int'(flip[6:4]) + 2);
		q = 32'(mag) << 16;
		return flip[7] ? q : 32'd0 - q;
	endfunction

	function automatic void float_to_q31(input logic [31:0] w, output logic [SampleW-1:0] v,
			output logic c);
		logic [7:0]         ex;
		logic [SampleW-1:0] sig;
		logic [SampleW-1:0] mag;
		ex  = w[30:23];
		sig = {9'd0, 1'b1, w[22:0]};
		c   = 1'b0;
		v   = '0;
		if (ex == 8'hFF && w[22:0] != 23'd0) begin
			c = 1'b1;                          // NaN: zero, flagged
		end else if (ex == 8'd127 && w[31] && w[22:0] == 23'd0) begin
			v = 32'h8000_0000;                 // exactly -1.0 fits
		end else if (ex >= 8'd127) begin
			c = 1'b1;
			v = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			if (ex == 8'd0)
				mag = '0;                      // zero and denormals
			else if (ex >= 8'(Q31Exp))
				mag = sig << (ex - 8'(Q31Exp));
			else if (8'(Q31Exp) - ex >= 8'd32)
				mag = '0;
			else
				mag = sig >> (8'(Q31Exp) - ex);
			v = w[31] ? 32'd0 - mag : mag;
		end
	endfunction

	// Applies one accepted byte to the model; returns 1 when it completes a sample.
	function automatic bit decode_byte(input logic [7:0] b, input logic rs,
			output pcm_sample_t s);
		int unsigned        size;
		int unsigned        width;
		int unsigned        nch;
		logic [SampleW-1:0] word;
		logic [FramesW-1:0] fpb_eff;
		s = '0;
		if (rs) begin
			held_bytes  = '0;
			held_count  = '0;
			chan_now    = '0;
			frames_seen = '0;
		end
		if (enc_reg == EncReserved)
			return 1'b0;
		size = sample_bytes(enc_reg);
		if (int'(held_count) + 1 < size) begin
			held_bytes = held_bytes | (24'(b) << (8 * held_count));
			held_count = held_count + 2'd1;
			return 1'b0;
		end
		// a size cut by an encoding change keeps only the low held bytes
		width = 8 * (size - 1);
		word  = ({8'h00, held_bytes} & ((32'd1 << width) - 32'd1)) | (32'(b) << width);
		held_bytes = '0;
		held_count = '0;
		case (enc_reg)
			ENC_U8:    s.value = {word[7] ^ 1'b1, word[6:0], 24'h0};
			ENC_S16:   s.value = {word[15:0], 16'h0};
			ENC_S24:   s.value = {word[23:0], 8'h0};
			ENC_S32:   s.value = word;
			ENC_MULAW: s.value = mu_expand(word[7:0]);
			ENC_ALAW:  s.value = a_expand(word[7:0]);
			default:   float_to_q31(word, s.value, s.clip);
		endcase
		if (chans_reg == '0)
			nch = 1;
		else if (chans_reg > MaxChannels)
			nch = MaxChannels;
		else
			nch = chans_reg;
		fpb_eff = (frames_reg == '0) ? 32'd1 : frames_reg;
		s.chan = chan_now;
		s.fend = (int'(chan_now) + 1 >= nch);
		s.bend = s.fend && (64'(frames_seen) + 64'd1 >= 64'(fpb_eff));
		if (s.fend) begin
			chan_now    = '0;
			frames_seen = s.bend ? '0 : frames_seen + 32'd1;
		end else begin
			chan_now = chan_now + 3'd1;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------------
	// Handshake helpers
	// ---------------------------------------------------------------------------
	// per-transfer random wait; now and then a side flips into a run with no waits
	function automatic int unsigned pick_wait(inout bit steady);
		if ($urandom_range(0, 31) == 0)
			steady = !steady;
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	// drives one byte, holds it until taken, then scores it in the model
	task automatic push_byte(input logic [7:0] b, input logic rs, input bit typed,
			input pcm_sample_t want);
		int unsigned gap;
		pcm_sample_t predicted;
		bit          made;
		gap = pick_wait(src_steady);
		@(negedge clk);
		if (gap != 0) begin
			byte_link.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_link.valid         <= 1'b1;
		byte_link.data_byte     <= b;
		byte_link.restart_frame <= rs;
		do @(posedge clk); while (!byte_link.ready);
		bytes_moved++;
		made = decode_byte(b, rs, predicted);
		// a typed row stands in for the model's answer
		if (made || typed)
			due_samples.push_back(typed ? want : predicted);
	endtask

	// stop sending and let the block drain before touching registers
	task automatic settle();
		@(negedge clk);
		byte_link.valid <= 1'b0;
		while (due_samples.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= data;
		@(posedge clk);
		case (idx)
			REG_SAMPLE_ENCODING:  enc_reg    = data[EncW-1:0];
			REG_CHANNEL_COUNT:    chans_reg  = data[ChanCountW-1:0];
			REG_FRAMES_PER_BLOCK: frames_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [SampleW-1:0] random_word(input logic [EncW-1:0] e);
		logic [7:0]  ex;
		logic [22:0] fr;
		// outside float, any bit pattern is a legal sample; one in 16 floats is raw noise
		if (e != ENC_FLOAT32 || $urandom_range(0, 15) == 0)
			return $urandom;
		case ($urandom_range(0, 7))
			0:       ex = 8'h00;
			1:       ex = 8'hFF;
			2:       ex = 8'd127;
			3:       ex = 8'($urandom_range(0, 255));
			default: ex = 8'($urandom_range(95, 130));
		endcase
		fr = 23'($urandom);
		if ((ex == 8'hFF || ex == 8'd127 || ex == 8'h00) && $urandom_range(0, 1) == 0)
			fr = '0;
		return {1'($urandom_range(0, 1)), ex, fr};
	endfunction

	// ---------------------------------------------------------------------------
	// Directed script rows
	// ---------------------------------------------------------------------------
	function automatic dir_row_t write_row(input reg_index_t i, input logic [CfgDataW-1:0] d);
		dir_row_t r;
		r = '{ROW_WRITE, i, d, 8'h00, 1'b0, pcm_sample_t'(0)};
		return r;
	endfunction

	function automatic dir_row_t byte_row(input logic [7:0] b, input logic rs);
		dir_row_t r;
		r = '{ROW_BYTE, REG_SAMPLE_ENCODING, 32'd0, b, rs, pcm_sample_t'(0)};
		return r;
	endfunction

	function automatic dir_row_t checked_row(input logic [7:0] b, input logic rs,
			input logic [SampleW-1:0] v, input logic [ChanIndexW-1:0] ch,
			input logic fe, input logic be, input logic cl);
		dir_row_t r;
		r = '{ROW_BYTE_CHECKED, REG_SAMPLE_ENCODING, 32'd0, b, rs, '{v, ch, fe, be, cl}};
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// Result side: random stalls on ready, scoring on every transfer
	// ---------------------------------------------------------------------------
	initial begin
		int unsigned hold;
		sample_link.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = pick_wait(sink_steady);
			@(negedge clk);
			if (hold != 0) begin
				sample_link.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			sample_link.ready <= 1'b1;
			do @(posedge clk); while (!(sample_link.valid && sample_link.ready));
		end
	end

	task automatic note_field(input string field, input logic [SampleW-1:0] want,
			input logic [SampleW-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && sample_link.valid && sample_link.ready) begin
			got_sample = '{sample_link.sample_value, sample_link.channel_index,
				sample_link.frame_end, sample_link.block_end, sample_link.clipped};
			samples_seen++;
			if (got_sample.clip === 1'b1)
				clips_seen++;
			if (got_sample.bend === 1'b1)
				block_ends_seen++;
			if (due_samples.size() == 0) begin
				errors++;
				$display("%0t: sample with nothing due, expected none, got %h ch %0d",
					$time, got_sample.value, got_sample.chan);
			end else begin
				want_sample = due_samples.pop_front();
				note_field("sample_value", want_sample.value, got_sample.value);
				note_field("channel_index", 32'(want_sample.chan), 32'(got_sample.chan));
				note_field("frame_end", 32'(want_sample.fend), 32'(got_sample.fend));
				note_field("block_end", 32'(want_sample.bend), 32'(got_sample.bend));
				note_field("clipped", 32'(want_sample.clip), 32'(got_sample.clip));
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------
	initial begin
		int unsigned       payload_bytes;
		int unsigned       nsamp;
		int unsigned       size;
		logic [EncW-1:0]   enc_pick;
		logic [31:0]       word;
		logic              rs;

		arst_n                  = 1'b0;
		cfg_write_en            = 1'b0;
		cfg_index               = REG_SAMPLE_ENCODING;
		cfg_data                = '0;
		byte_link.valid         = 1'b0;
		byte_link.data_byte     = '0;
		byte_link.restart_frame = 1'b0;
		errors          = 0;
		bytes_moved     = 0;
		samples_seen    = 0;
		clips_seen      = 0;
		block_ends_seen = 0;
		phases_run      = 0;
		payload_bytes   = 0;
		src_steady      = 1'b0;
		sink_steady     = 1'b0;

		enc_reg     = EncReset;
		chans_reg   = ChanReset;
		frames_reg  = FramesReset;
		held_bytes  = '0;
		held_count  = '0;
		chan_now    = '0;
		frames_seen = '0;

		// Directed script. Typed expectations run at one channel, one frame per block,
		// so every sample closes its frame and its block.
		script = '{
			// reset state is s16: most negative 16-bit sample
			byte_row(8'h00, 1'b1),
			checked_row(8'h80, 1'b0, 32'h8000_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// unsigned 8-bit extremes
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_U8)),
			checked_row(8'h00, 1'b0, 32'h8000_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			checked_row(8'hFF, 1'b0, 32'h7F00_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// largest mu-law magnitude, negative: -32124
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_MULAW)),
			checked_row(8'h00, 1'b0, 32'h8284_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// smallest A-law step, negative: -8
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_ALAW)),
			checked_row(8'h55, 1'b0, 32'hFFF8_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// reserved code: byte dropped, restart still clears the counters
			write_row(REG_SAMPLE_ENCODING, 32'(EncReserved)),
			byte_row(8'h12, 1'b1),
			// float with zero channel count and zero frames per block, both acting as 1
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_FLOAT32)),
			write_row(REG_CHANNEL_COUNT, 32'd0),
			write_row(REG_FRAMES_PER_BLOCK, 32'd0),
			// -1.0 is exact and not flagged
			byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h80, 1'b0),
			checked_row(8'hBF, 1'b0, 32'h8000_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// +infinity saturates
			byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h80, 1'b0),
			checked_row(8'h7F, 1'b0, 32'h7FFF_FFFF, 3'd0, 1'b1, 1'b1, 1'b1),
			// quiet NaN gives zero, flagged
			byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'hC0, 1'b0),
			checked_row(8'h7F, 1'b0, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 1'b1),
			// negative denormal flushes to zero
			byte_row(8'h01, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
			checked_row(8'h80, 1'b0, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 1'b0),
			// channel count above the maximum, then s24 cut to s16 mid-sample
			write_row(REG_CHANNEL_COUNT, 32'd9),
			write_row(REG_FRAMES_PER_BLOCK, 32'd2),
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_S24)),
			byte_row(8'h34, 1'b0), byte_row(8'h12, 1'b0),
			write_row(REG_SAMPLE_ENCODING, 32'(ENC_S16)),
			byte_row(8'hAB, 1'b0)
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				settle();
				write_reg(script[i].idx, script[i].wdata);
			end else begin
				push_byte(script[i].b, script[i].rs, script[i].kind == ROW_BYTE_CHECKED,
					script[i].want);
			end
		end

		// Random phases: fresh settings each time, mostly whole samples with random
		// content, some restarts inside samples and some trailing partial samples so
		// that the next encoding meets a half-built one.
		while (payload_bytes < RandomBytes) begin
			settle();
			phases_run++;
			enc_pick = ($urandom_range(0, 15) == 0) ? EncReserved : 3'($urandom_range(0, 6));
			write_reg(REG_SAMPLE_ENCODING, 32'(enc_pick));
			case ($urandom_range(0, 5))
				0:       write_reg(REG_CHANNEL_COUNT, 32'd0);
				1:       write_reg(REG_CHANNEL_COUNT, 32'd15);
				2:       write_reg(REG_CHANNEL_COUNT, 32'(MaxChannels));
				3:       write_reg(REG_CHANNEL_COUNT, 32'($urandom_range(9, 14)));
				default: write_reg(REG_CHANNEL_COUNT, 32'($urandom_range(1, MaxChannels)));
			endcase
			case ($urandom_range(0, 5))
				0:       write_reg(REG_FRAMES_PER_BLOCK, 32'd0);
				1:       write_reg(REG_FRAMES_PER_BLOCK, 32'hFFFF_FFFF);
				2:       write_reg(REG_FRAMES_PER_BLOCK, $urandom);
				default: write_reg(REG_FRAMES_PER_BLOCK, 32'($urandom_range(1, 5)));
			endcase

			size  = sample_bytes(enc_reg);
			nsamp = $urandom_range(4, 40);
			repeat (nsamp) begin
				word = random_word(enc_reg);
				for (int k = 0; k < size; k++) begin
					if (enc_reg == EncReserved)
						rs = ($urandom_range(0, 3) == 0);
					else if (k == 0)
						rs = ($urandom_range(0, 39) == 0);
					else
						rs = ($urandom_range(0, 79) == 0);   // breaks the sample
					push_byte(word[8 * k +: 8], rs, 1'b0, pcm_sample_t'(0));
					if (enc_reg != EncReserved)
						payload_bytes++;
				end
			end
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					push_byte(8'($urandom), 1'b0, 1'b0, pcm_sample_t'(0));
					if (enc_reg != EncReserved)
						payload_bytes++;
				end
			end
		end

		settle();
		$display("run covered %0d byte transfers over %0d random settings plus the script",
			bytes_moved, phases_run);
		$display("%0d samples scored, %0d clipped, %0d block ends, %0d errors",
			samples_seen, clips_seen, block_ends_seen, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Hard stop in case the run hangs.
	initial begin
		#2_000_000;
		$display("timeout with %0d samples still due", due_samples.size());
		$display("tb: failure");
		$finish;
	end

endmodule
